FILE: rtl/seq_pkg.sv
// shared types and constants for the sorted event time queue
package seq_pkg;

  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned TIME_BITS   = 32;
  localparam int unsigned HANDLE_BITS = 16;
  localparam int unsigned IDX_BITS    = $clog2(CAPACITY);
  localparam int unsigned CNT_BITS    = $clog2(CAPACITY + 1);

  localparam int unsigned OP_BITS   = 2;
  localparam int unsigned ST_BITS   = 2;
  localparam int unsigned POS_BITS  = 8;
  localparam int unsigned FPOS_BITS = 7;
  localparam int unsigned TOL_BITS  = 32;

  // position value meaning no position
  localparam logic [POS_BITS-1:0] POS_NONE = '1;

  typedef enum logic [OP_BITS-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [ST_BITS-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_POS   = 2'd3
  } status_e;

  typedef struct packed {
    logic [OP_BITS-1:0]     operation;
    logic [TIME_BITS-1:0]   event_time;
    logic [HANDLE_BITS-1:0] event_handle;
    logic [POS_BITS-1:0]    position;
  } seq_req_t;

  typedef struct packed {
    logic [ST_BITS-1:0]     status;
    logic [FPOS_BITS-1:0]   found_position;
    logic [TIME_BITS-1:0]   found_time;
    logic [HANDLE_BITS-1:0] found_handle;
    logic [FPOS_BITS-1:0]   entry_count;
  } seq_rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture transaction
    logic scan;   // one step of the entry walk
    logic finish; // last insert write, count update, capture the result
  } seq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_done;
  } seq_sts_t;

endpackage

FILE: rtl/seq_if.sv
// valid ready channel carrying a generic payload
interface seq_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/seq_ctrl.sv
// controller state machine for the sorted event time queue
module seq_ctrl
  import seq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  seq_sts_t sts_i,
  output seq_cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.walk_done) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_SCAN)
    else $error("load did not start a scan");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_q)
    else $error("result not presented after finish");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !in_ready_o)
    else $error("input taken while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q)
    else $error("result dropped while stalled");

endmodule

FILE: rtl/seq_dp.sv
// datapath of the sorted event time queue: entry memory, walk and shift
module seq_dp
  import seq_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  seq_cmd_t               cmd_i,
  output seq_sts_t               sts_o,
  input  logic [TOL_BITS-1:0]    tolerance_i,
  input  logic [OP_BITS-1:0]     operation_i,
  input  logic [TIME_BITS-1:0]   event_time_i,
  input  logic [HANDLE_BITS-1:0] event_handle_i,
  input  logic [POS_BITS-1:0]    position_i,
  output logic [ST_BITS-1:0]     status_o,
  output logic [FPOS_BITS-1:0]   found_position_o,
  output logic [TIME_BITS-1:0]   found_time_o,
  output logic [HANDLE_BITS-1:0] found_handle_o,
  output logic [FPOS_BITS-1:0]   entry_count_o
);

  localparam int unsigned TW = (TIME_BITS > TOL_BITS) ? TIME_BITS : TOL_BITS;

  // one registered read and one write per cycle
  logic [TIME_BITS-1:0]   mem_t [CAPACITY];
  logic [HANDLE_BITS-1:0] mem_h [CAPACITY];

  logic [CNT_BITS-1:0]    count_q, count_d;
  op_e                    op_q;
  logic                   pos_ok_q, pos_none_q, full_q;
  logic [CNT_BITS-1:0]    ptr_q, end_q;
  logic                   rd_valid_q, hit_q;
  logic [TIME_BITS-1:0]   key_q, carry_t_q, rd_t_q, hit_t_q;
  logic [HANDLE_BITS-1:0] hdl_q, carry_h_q, rd_h_q, hit_h_q;
  logic [CNT_BITS-1:0]    pos_q, rd_addr_q, hit_pos_q;

  op_e                    op_w;
  logic                   pos_ok_w, pos_none_w, full_w;
  logic [CNT_BITS-1:0]    pos_w, start_w, end_w;
  logic [TW-1:0]          a_w, b_w, diff_w;
  logic                   eq_w, later_w, match_w, issue_w, take_w, shift_w;
  logic                   wr_en_w;
  logic [IDX_BITS-1:0]    wr_addr_w;
  logic [TIME_BITS-1:0]   wr_t_w;
  logic [HANDLE_BITS-1:0] wr_h_w;
  status_e                res_st_w;
  logic [CNT_BITS-1:0]    res_pos_w;
  logic [TIME_BITS-1:0]   res_t_w;
  logic [HANDLE_BITS-1:0] res_h_w;

  // decode of the incoming transaction
  assign op_w       = op_e'(operation_i);
  assign pos_w      = CNT_BITS'(position_i[POS_BITS-2:0]);
  assign pos_none_w = (position_i == POS_NONE);
  assign pos_ok_w   = !position_i[POS_BITS-1] && (pos_w != '0) && (pos_w <= count_q);
  assign full_w     = (count_q == CNT_BITS'(CAPACITY));

  // walk bounds: insert, search all; delete from position; read one; else none
  always_comb begin
    start_w = '0;
    end_w   = '0;
    unique case (op_w)
      OP_INSERT: end_w = full_w ? '0 : count_q;
      OP_SEARCH: end_w = count_q;
      OP_READ: begin
        if (pos_ok_w) begin
          start_w = pos_w - CNT_BITS'(1);
          end_w   = pos_w;
        end
      end
      OP_DELETE: begin
        if (pos_ok_w) begin
          start_w = pos_w - CNT_BITS'(1);
          end_w   = count_q;
        end
      end
    endcase
  end

  assign a_w     = TW'(rd_t_q);
  assign b_w     = TW'(key_q);
  assign diff_w  = (a_w >= b_w) ? (a_w - b_w) : (b_w - a_w);
  assign eq_w    = (diff_w == '0) || (diff_w < TW'(tolerance_i));
  assign later_w = (rd_t_q > key_q) && !eq_w;

  always_comb begin
    unique case (op_q)
      OP_INSERT: match_w = later_w;
      OP_SEARCH: match_w = eq_w;
      default:   match_w = 1'b1;
    endcase
  end

  assign issue_w = cmd_i.scan && (ptr_q < end_q);
  assign take_w  = cmd_i.scan && rd_valid_q && !hit_q && match_w;
  assign shift_w = cmd_i.scan && rd_valid_q && (op_q == OP_INSERT) && (hit_q || match_w);

  assign sts_o.walk_done = (ptr_q >= end_q) && !rd_valid_q;

  // insert ripples the carried entry up, delete moves entries down by one
  always_comb begin
    wr_en_w   = 1'b0;
    wr_addr_w = '0;
    wr_t_w    = carry_t_q;
    wr_h_w    = carry_h_q;
    if (shift_w) begin
      wr_en_w   = 1'b1;
      wr_addr_w = rd_addr_q[IDX_BITS-1:0];
    end else if (cmd_i.scan && rd_valid_q && (op_q == OP_DELETE) && hit_q) begin
      wr_en_w   = 1'b1;
      wr_addr_w = rd_addr_q[IDX_BITS-1:0] - IDX_BITS'(1);
      wr_t_w    = rd_t_q;
      wr_h_w    = rd_h_q;
    end else if (cmd_i.finish && (op_q == OP_INSERT) && !full_q) begin
      wr_en_w   = 1'b1;
      wr_addr_w = count_q[IDX_BITS-1:0];
    end
  end

  always_comb begin
    count_d = count_q;
    if ((op_q == OP_INSERT) && !full_q) begin
      count_d = count_q + CNT_BITS'(1);
    end else if ((op_q == OP_DELETE) && pos_ok_q) begin
      count_d = count_q - CNT_BITS'(1);
    end
  end

  always_comb begin
    res_st_w  = ST_OK;
    res_pos_w = '0;
    res_t_w   = '0;
    res_h_w   = '0;
    unique case (op_q)
      OP_INSERT: begin
        res_t_w = key_q;
        res_h_w = hdl_q;
        if (full_q) begin
          res_st_w = ST_FULL;
        end else begin
          res_pos_w = hit_q ? hit_pos_q : count_q + CNT_BITS'(1);
        end
      end
      OP_SEARCH: begin
        if (hit_q) begin
          res_pos_w = hit_pos_q;
          res_t_w   = hit_t_q;
          res_h_w   = hit_h_q;
        end else begin
          res_st_w = ST_NOT_FOUND;
        end
      end
      default: begin
        if (!((op_q == OP_DELETE) && pos_none_q)) begin
          if (!pos_ok_q) begin
            res_st_w = ST_BAD_POS;
          end else begin
            res_pos_w = pos_q;
            res_t_w   = hit_t_q;
            res_h_w   = hit_h_q;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q          <= '0;
      op_q             <= OP_INSERT;
      pos_ok_q         <= 1'b0;
      pos_none_q       <= 1'b0;
      full_q           <= 1'b0;
      ptr_q            <= '0;
      end_q            <= '0;
      rd_valid_q       <= 1'b0;
      hit_q            <= 1'b0;
      status_o         <= ST_OK;
      found_position_o <= '0;
      found_time_o     <= '0;
      found_handle_o   <= '0;
      entry_count_o    <= '0;
    end else begin
      if (cmd_i.load) begin
        op_q       <= op_w;
        pos_ok_q   <= pos_ok_w;
        pos_none_q <= pos_none_w;
        full_q     <= full_w;
        ptr_q      <= start_w;
        end_q      <= end_w;
        rd_valid_q <= 1'b0;
        hit_q      <= 1'b0;
      end
      if (cmd_i.scan) begin
        rd_valid_q <= issue_w;
        if (issue_w) begin
          ptr_q <= ptr_q + CNT_BITS'(1);
        end
        if (take_w) begin
          hit_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        count_q          <= count_d;
        status_o         <= res_st_w;
        found_position_o <= FPOS_BITS'(res_pos_w);
        found_time_o     <= res_t_w;
        found_handle_o   <= res_h_w;
        entry_count_o    <= FPOS_BITS'(count_d);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q     <= event_time_i;
      hdl_q     <= event_handle_i;
      pos_q     <= pos_w;
      carry_t_q <= event_time_i;
      carry_h_q <= event_handle_i;
    end
    if (issue_w) begin
      rd_t_q    <= mem_t[ptr_q[IDX_BITS-1:0]];
      rd_h_q    <= mem_h[ptr_q[IDX_BITS-1:0]];
      rd_addr_q <= ptr_q;
    end
    if (take_w) begin
      hit_pos_q <= rd_addr_q + CNT_BITS'(1);
      hit_t_q   <= rd_t_q;
      hit_h_q   <= rd_h_q;
    end
    if (shift_w) begin
      carry_t_q <= rd_t_q;
      carry_h_q <= rd_h_q;
    end
    if (wr_en_w) begin
      mem_t[wr_addr_w] <= wr_t_w;
      mem_h[wr_addr_w] <= wr_h_w;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_BITS'(CAPACITY))
    else $error("count beyond capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> !rd_valid_q && !hit_q)
    else $error("walk state not cleared at load");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> rd_addr_q < count_q)
    else $error("read beyond held entries");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_w |-> (op_q == OP_INSERT) || (op_q == OP_DELETE))
    else $error("memory write outside insert or delete");

endmodule

FILE: rtl/sorted_event_time_queue.sv
// top level of the sorted event time queue
// usage:
//   in channel carries operation, event_time, event_handle, position;
//   out channel returns status, found_position, found_time, found_handle
//   and entry_count, one result transaction per input transaction.
//   tolerance is written through cfg_we_i / cfg_wdata_i; the user must
//   write it only while idle, which the block itself does not enforce.
// operation:
//   one operation at a time; an operation walks n entries of the memory,
//   one per cycle through its single registered read port: insert and
//   search walk all count entries, delete walks from its position to the
//   end, read walks one, rejected operations walk none. the result is
//   registered in the output registers when the walk is done; the next
//   input is taken the cycle after the result is taken.
// reset:
//   rst_ni empties the queue and clears tolerance; entries are not cleared.
// stall:
//   the result is held in the output register until taken; no new input
//   transaction is accepted while a result waits.
module sorted_event_time_queue
  import seq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [TOL_BITS-1:0] cfg_wdata_i,
  seq_if.sink                 in_if,
  seq_if.source               out_if
);

  seq_cmd_t            cmd;
  seq_sts_t            sts;
  logic [TOL_BITS-1:0] tolerance_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tolerance_q <= '0;
    end else if (cfg_we_i) begin
      tolerance_q <= cfg_wdata_i;
    end
  end

  seq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  seq_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .tolerance_i     (tolerance_q),
    .operation_i     (in_if.payload.operation),
    .event_time_i    (in_if.payload.event_time),
    .event_handle_i  (in_if.payload.event_handle),
    .position_i      (in_if.payload.position),
    .status_o        (out_if.payload.status),
    .found_position_o(out_if.payload.found_position),
    .found_time_o    (out_if.payload.found_time),
    .found_handle_o  (out_if.payload.found_handle),
    .entry_count_o   (out_if.payload.entry_count)
  );

endmodule

FILE: tb/tb_types.sv
`timescale 1ns / 1ps
// request and response transaction types for the event queue testbench
package tb_types;
  import seq_pkg::*;

  typedef seq_req_t req_t;
  typedef seq_rsp_t rsp_t;
endpackage

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// testbench for the sorted event time queue with a predictor and a scoreboard
module testbench;
  import seq_pkg::*;
  import tb_types::*;

  localparam int DEPTH = CAPACITY;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  always #1 clk_i = ~clk_i;

  seq_if #(.payload_t(req_t)) in_ch ();
  seq_if #(.payload_t(rsp_t)) out_ch ();

  sorted_event_time_queue uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_if(in_ch.sink), .out_if(out_ch.source)
  );

  // predictor state
  logic [31:0] q_time[DEPTH];
  logic [15:0] q_handle[DEPTH];
  int unsigned q_count = 0;
  logic [31:0] q_tol = '0;

  rsp_t pending[$];
  int errors = 0;
  int send_idle = 7;
  int recv_idle = 72;
  bit hold_off = 0;

  function automatic bit same_time(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = (a >= b) ? a - b : b - a;
    return d == 0 || d < q_tol;
  endfunction

  function automatic rsp_t queue_apply(req_t r);
    rsp_t o;
    int at;
    int p;
    o = '0;
    p = $signed(r.position);
    unique case (op_e'(r.operation))
      OP_INSERT: begin
        if (q_count >= DEPTH) begin
          o.status = ST_FULL;
          o.found_time = r.event_time;
          o.found_handle = r.event_handle;
        end else begin
          at = q_count;
          for (int i = 0; i < q_count; i++) begin
            if (q_time[i] > r.event_time && !same_time(q_time[i], r.event_time)) begin
              at = i;
              break;
            end
          end
          for (int i = q_count; i > at; i--) begin
            q_time[i] = q_time[i-1];
            q_handle[i] = q_handle[i-1];
          end
          q_time[at] = r.event_time;
          q_handle[at] = r.event_handle;
          q_count++;
          o.status = ST_OK;
          o.found_position = 7'(at + 1);
          o.found_time = r.event_time;
          o.found_handle = r.event_handle;
        end
      end
      OP_SEARCH: begin
        o.status = ST_NOT_FOUND;
        for (int i = 0; i < q_count; i++) begin
          if (same_time(q_time[i], r.event_time)) begin
            o.status = ST_OK;
            o.found_position = 7'(i + 1);
            o.found_time = q_time[i];
            o.found_handle = q_handle[i];
            break;
          end
        end
      end
      default: begin
        if (op_e'(r.operation) == OP_DELETE && p == -1) begin
          o.status = ST_OK;
        end else if (p < 1 || p > int'(q_count)) begin
          o.status = ST_BAD_POS;
        end else begin
          o.status = ST_OK;
          o.found_position = 7'(p);
          o.found_time = q_time[p-1];
          o.found_handle = q_handle[p-1];
          if (op_e'(r.operation) == OP_DELETE) begin
            for (int i = p - 1; i + 1 < q_count; i++) begin
              q_time[i] = q_time[i+1];
              q_handle[i] = q_handle[i+1];
            end
            q_count--;
          end
        end
      end
    endcase
    o.entry_count = 7'(q_count);
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  // stores the predicted result, or a typed-in one when given
  task automatic send(req_t r, bit fixed = 0, rsp_t want = '0);
    rsp_t e;
    e = queue_apply(r);
    pending.push_back(fixed ? want : e);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= r;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending.size() != 0) @(negedge clk_i);
    repeat (DEPTH + 10) @(negedge clk_i);
  endtask

  task automatic set_tolerance(logic [31:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    q_tol = v;
  endtask

  function automatic req_t mk(op_e op, logic [31:0] t, logic [15:0] h, logic [7:0] p);
    req_t r;
    r.operation = op;
    r.event_time = t;
    r.event_handle = h;
    r.position = p;
    return r;
  endfunction

  function automatic rsp_t rs(status_e st, logic [6:0] fp, logic [31:0] ft,
                              logic [15:0] fh, logic [6:0] c);
    rsp_t o;
    o.status = st;
    o.found_position = fp;
    o.found_time = ft;
    o.found_handle = fh;
    o.entry_count = c;
    return o;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int k;
    r.operation = 2'($urandom_range(3));
    k = $urandom_range(9);
    if (k < 3) r.event_time = $urandom();
    else if (k < 5 && q_count > 0)
      r.event_time = 32'(q_time[$urandom_range(q_count - 1)] + $urandom_range(8) - 4);
    else r.event_time = 32'($urandom_range(4000));
    r.event_handle = 16'($urandom());
    k = $urandom_range(9);
    if (k == 0) r.position = 8'($urandom());
    else if (k == 1) r.position = 8'hff;
    else r.position = 8'($urandom_range(q_count + 1));
    return r;
  endfunction

  // receiver
  always @(negedge clk_i) begin
    if (hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    rsp_t g;
    rsp_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      g = out_ch.payload;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result transaction", 32'd1, 32'd0);
      end else begin
        e = pending.pop_front();
        if (g.status !== e.status)
          report_mismatch("status", 32'(g.status), 32'(e.status));
        if (g.found_position !== e.found_position)
          report_mismatch("found_position", 32'(g.found_position), 32'(e.found_position));
        if (g.found_time !== e.found_time)
          report_mismatch("found_time", g.found_time, e.found_time);
        if (g.found_handle !== e.found_handle)
          report_mismatch("found_handle", 32'(g.found_handle), 32'(e.found_handle));
        if (g.entry_count !== e.entry_count)
          report_mismatch("entry_count", 32'(g.entry_count), 32'(e.entry_count));
      end
    end
  end

  typedef struct {
    req_t r;
    bit   fixed;
    rsp_t want;
  } row_t;

  row_t rows[$];

  initial begin
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    rows = '{
      '{mk(OP_READ, 32'd0, 16'd0, 8'd1), 1'b1, rs(ST_BAD_POS, 7'd0, 32'd0, 16'd0, 7'd0)},
      '{mk(OP_SEARCH, 32'd5, 16'd0, 8'd0), 1'b1,
        rs(ST_NOT_FOUND, 7'd0, 32'd0, 16'd0, 7'd0)},
      '{mk(OP_DELETE, 32'd0, 16'd0, 8'hff), 1'b1, rs(ST_OK, 7'd0, 32'd0, 16'd0, 7'd0)},
      '{mk(OP_DELETE, 32'd0, 16'd0, 8'd1), 1'b1, rs(ST_BAD_POS, 7'd0, 32'd0, 16'd0, 7'd0)},
      '{mk(OP_INSERT, 32'hffffffff, 16'hffff, 8'd0), 1'b1,
        rs(ST_OK, 7'd1, 32'hffffffff, 16'hffff, 7'd1)},
      '{mk(OP_INSERT, 32'd0, 16'd0, 8'd0), 1'b1, rs(ST_OK, 7'd1, 32'd0, 16'd0, 7'd2)},
      '{mk(OP_INSERT, 32'd100, 16'h1234, 8'd0), 1'b0, '0},
      '{mk(OP_INSERT, 32'd100, 16'h5678, 8'd0), 1'b0, '0},
      '{mk(OP_SEARCH, 32'd100, 16'd0, 8'd0), 1'b0, '0},
      '{mk(OP_READ, 32'd0, 16'd0, 8'd4), 1'b0, '0},
      '{mk(OP_READ, 32'd0, 16'd0, 8'h7f), 1'b1, rs(ST_BAD_POS, 7'd0, 32'd0, 16'd0, 7'd4)},
      '{mk(OP_READ, 32'd0, 16'd0, 8'h80), 1'b1, rs(ST_BAD_POS, 7'd0, 32'd0, 16'd0, 7'd4)},
      '{mk(OP_READ, 32'd0, 16'd0, 8'd0), 1'b1, rs(ST_BAD_POS, 7'd0, 32'd0, 16'd0, 7'd4)},
      '{mk(OP_READ, 32'd0, 16'd0, 8'hff), 1'b1, rs(ST_BAD_POS, 7'd0, 32'd0, 16'd0, 7'd4)},
      '{mk(OP_DELETE, 32'd0, 16'd0, 8'd2), 1'b0, '0},
      '{mk(OP_DELETE, 32'd0, 16'd0, 8'd5), 1'b1, rs(ST_BAD_POS, 7'd0, 32'd0, 16'd0, 7'd3)},
      '{mk(OP_SEARCH, 32'hfffffffe, 16'd0, 8'd0), 1'b0, '0}
    };
    foreach (rows[i]) send(rows[i].r, rows[i].fixed, rows[i].want);
    drain();

    // tolerance makes near times tie, plus fill to capacity and overflow
    set_tolerance(32'd10);
    for (int i = 0; i < 70; i++)
      send(mk(OP_INSERT, 32'($urandom_range(300)), 16'($urandom()), 8'd0));
    send(mk(OP_SEARCH, 32'd150, 16'd0, 8'd0));
    send(mk(OP_READ, 32'd0, 16'd0, 8'd64));
    send(mk(OP_DELETE, 32'd0, 16'd0, 8'd64));
    send(mk(OP_DELETE, 32'd0, 16'd0, 8'd65));
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 7 : (ph == 1) ? 72 : 0;
      recv_idle = (ph == 0) ? 72 : (ph == 1) ? 7 : 0;
      set_tolerance(ph == 0 ? 32'hffffffff : ph == 1 ? 32'd3 : 32'd0);
      for (int n = 0; n < 420; n++) begin
        req_t r;
        r = rand_req();
        if (q_count < 20 && $urandom_range(9) < 4) r.operation = OP_INSERT;
        if (q_count > 50 && $urandom_range(9) < 4) r.operation = OP_DELETE;
        if (ph == 2 && n == 100) begin
          fork
            begin
              hold_off = 1;
              repeat (300) @(negedge clk_i);
              hold_off = 0;
            end
          join_none
        end
        send(r);
      end
      drain();
    end

    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
